[hw/rtl/qpht_pkg.sv]
// shared types and constants for the quadratic probe hash table
`default_nettype none

package qpht_pkg;

    localparam int TABLE_SIZE_DEFAULT = 4093;

    localparam int KEY_W    = 31;
    localparam int LIMIT_W  = 12;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 12;
    localparam int COUNT_W  = 12;
    localparam int STORED_W = 13;
    localparam int COLL_W   = 32;

    localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RESET = 12'd4093;

    // key mod table size: reciprocal multiply, multiply-subtract, final correction
    localparam int MOD_STEPS = 3;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic    clr;
        logic    load;
        logic    mod_step;
        logic    probe_rd;
        logic    advance;
        logic    store;
        logic    out_load;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic slot_valid;
        logic key_match;
        logic at_limit;
        logic is_search;
    } t_sts;

endpackage

`default_nettype wire

[hw/rtl/quadratic_probe_hash_table.sv]
// top level of the quadratic probe hash table
//
// Open-addressed key set. Each request word on the input channel (i_in_valid,
// o_in_ready) carries i_cmd (0 insert, 1 search) and a 31-bit i_key. Each
// request gives exactly one result word on the output channel (o_out_valid,
// i_out_ready): status, slot index, item count and collision total.
// The probe limit is written through i_cfg_valid / o_cfg_ready with the new
// value on i_cfg_probe_limit; write it only while no request is in flight.
// After reset the valid map is swept clear, one slot a cycle, across all TABLE_SIZE
// slots; o_in_ready stays low during the sweep. Reset also clears the item
// count and collision total and sets the probe limit to 4093.
// Requests are handled one at a time. Home slot reduction comes first
// (reciprocal multiply, multiply-subtract, correction), each probe is a
// memory read followed by a compare, and the result is then registered.
// A new request is taken only once the result is registered. If the
// receiver stalls, the result word holds and the next request is processed
// but waits for its result until the word is taken.
`default_nettype none

module quadratic_probe_hash_table #(
    parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_cmd,
    input  wire logic [qpht_pkg::KEY_W-1:0]      i_key,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [qpht_pkg::STATUS_W-1:0]        o_status,
    output logic [qpht_pkg::SLOT_W-1:0]          o_slot_index,
    output logic [qpht_pkg::COUNT_W-1:0]         o_item_count,
    output logic [qpht_pkg::COLL_W-1:0]          o_collision_total,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [qpht_pkg::LIMIT_W-1:0]    i_cfg_probe_limit
);

    qpht_pkg::t_cmd cmd;
    qpht_pkg::t_sts sts;

    qpht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    qpht_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cmd_bit         (i_cmd),
        .i_key             (i_key),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_limit       (i_cfg_probe_limit),
        .o_status          (o_status),
        .o_slot_index      (o_slot_index),
        .o_item_count      (o_item_count),
        .o_collision_total (o_collision_total)
    );

    // the limit register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

[hw/rtl/qpht_ctrl.sv]
// controller state machine for the quadratic probe hash table
`default_nettype none

module qpht_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire qpht_pkg::t_sts i_sts,
    output qpht_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic              r_out_valid, n_out_valid;
    qpht_pkg::t_status r_status, n_status;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        o_cmd        = '0;
        o_cmd.status = r_status;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.probe_rd = 1'b1;
                n_state        = S_CHECK;
            end
            S_CHECK: begin
                priority if (!i_sts.slot_valid) begin
                    if (i_sts.is_search) begin
                        n_status = qpht_pkg::ST_NOT_FOUND;
                    end else begin
                        o_cmd.store = 1'b1;
                        n_status    = qpht_pkg::ST_INSERTED;
                    end
                    n_state = S_DONE;
                end else if (i_sts.key_match) begin
                    n_status = i_sts.is_search ? qpht_pkg::ST_FOUND : qpht_pkg::ST_DUPLICATE;
                    n_state  = S_DONE;
                end else if (i_sts.at_limit) begin
                    n_status = i_sts.is_search ? qpht_pkg::ST_NOT_FOUND : qpht_pkg::ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_DONE: begin
                // hold the result until the output word is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_status    <= qpht_pkg::ST_INSERTED;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[hw/rtl/qpht_datapath.sv]
// datapath: key and valid memories, modulo unit, probe index and counters
`default_nettype none

module qpht_datapath #(
    parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire qpht_pkg::t_cmd                  i_cmd,
    output qpht_pkg::t_sts                       o_sts,
    input  wire logic                            i_cmd_bit,
    input  wire logic [qpht_pkg::KEY_W-1:0]      i_key,
    input  wire logic                            i_cfg_we,
    input  wire logic [qpht_pkg::LIMIT_W-1:0]    i_cfg_limit,
    output logic [qpht_pkg::STATUS_W-1:0]        o_status,
    output logic [qpht_pkg::SLOT_W-1:0]          o_slot_index,
    output logic [qpht_pkg::COUNT_W-1:0]         o_item_count,
    output logic [qpht_pkg::COLL_W-1:0]          o_collision_total
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [IDX_W:0]   L_N    = (IDX_W + 1)'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] L_LAST = IDX_W'(TABLE_SIZE - 1);

    localparam int L_KEY_W  = qpht_pkg::KEY_W;
    localparam int RECIP_SH = L_KEY_W;
    localparam int PROD_W   = L_KEY_W + RECIP_SH;
    localparam int CNT_W    = qpht_pkg::MOD_CNT_W;
    // floor(2^31 / size): the quotient estimate is low by at most one
    localparam logic [L_KEY_W-1:0] L_RECIP =
        L_KEY_W'((64'd1 << RECIP_SH) / TABLE_SIZE);
    localparam logic [L_KEY_W-1:0] L_N_KEY    = L_KEY_W'(TABLE_SIZE);
    localparam logic [CNT_W-1:0]   L_MOD_LAST = CNT_W'(qpht_pkg::MOD_STEPS - 1);

    // memories
    logic [qpht_pkg::KEY_W-1:0] r_key_mem   [TABLE_SIZE];
    logic                       r_valid_mem [TABLE_SIZE];
    logic [qpht_pkg::KEY_W-1:0] r_rd_key;
    logic                       r_rd_valid;

    logic [IDX_W-1:0]              r_clr_addr;
    logic [qpht_pkg::LIMIT_W-1:0]  r_probe_limit;
    logic [qpht_pkg::KEY_W-1:0]    r_key;
    logic                          r_search;
    logic [qpht_pkg::KEY_W-1:0]    r_quot;
    logic [IDX_W:0]                r_rem_est;
    logic [CNT_W-1:0]              r_mod_cnt;
    logic [IDX_W-1:0]              r_idx;
    logic [IDX_W-1:0]              r_sq;
    logic [IDX_W-1:0]              r_odd;
    logic [qpht_pkg::LIMIT_W-1:0]  r_step;
    logic [qpht_pkg::STORED_W-1:0] r_stored;
    logic [qpht_pkg::COLL_W-1:0]   r_coll;

    logic [qpht_pkg::STATUS_W-1:0] r_out_status;
    logic [qpht_pkg::SLOT_W-1:0]   r_out_slot;
    logic [qpht_pkg::COUNT_W-1:0]  r_out_items;
    logic [qpht_pkg::COLL_W-1:0]   r_out_coll;

    logic [qpht_pkg::KEY_W-1:0] quot_n;
    logic [IDX_W-1:0] n_home;
    logic [IDX_W:0]   sq_sum;
    logic [IDX_W:0]   odd_sum;
    logic [IDX_W:0]   idx_sum;
    logic [IDX_W-1:0] n_sq;
    logic [IDX_W-1:0] n_odd;
    logic [IDX_W-1:0] n_idx;
    logic [31:0]      idx_ext;

    // remainder estimate lies below twice the size, one subtract finishes it
    always_comb begin
        quot_n = r_quot * L_N_KEY;
        n_home = (r_rem_est >= L_N) ? IDX_W'(r_rem_est - L_N) : r_rem_est[IDX_W-1:0];
    end

    // running square: (s+1)^2 = s^2 + (2s+1), both kept mod size
    always_comb begin
        sq_sum  = {1'b0, r_sq} + {1'b0, r_odd};
        odd_sum = {1'b0, r_odd} + (IDX_W + 1)'(2);
        idx_sum = {1'b0, r_idx} + {1'b0, r_sq};
        n_sq    = (sq_sum  >= L_N) ? IDX_W'(sq_sum  - L_N) : sq_sum[IDX_W-1:0];
        n_odd   = (odd_sum >= L_N) ? IDX_W'(odd_sum - L_N) : odd_sum[IDX_W-1:0];
        n_idx   = (idx_sum >= L_N) ? IDX_W'(idx_sum - L_N) : idx_sum[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr    <= '0;
            r_probe_limit <= qpht_pkg::PROBE_LIMIT_RESET;
            r_stored      <= '0;
            r_coll        <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                r_probe_limit <= i_cfg_limit;
            end
            if (i_cmd.store) begin
                r_stored <= r_stored + 1'b1;
            end
            if (i_cmd.advance && !r_search && (r_coll != '1)) begin
                r_coll <= r_coll + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key     <= i_key;
            r_search  <= i_cmd_bit;
            r_mod_cnt <= '0;
            r_sq      <= '0;
            r_odd     <= IDX_W'(1);
            r_step    <= '0;
        end
        // three-stage pipe on the held key: quotient, remainder estimate, home slot
        if (i_cmd.mod_step) begin
            r_quot    <= L_KEY_W'((PROD_W'(r_key) * PROD_W'(L_RECIP)) >> RECIP_SH);
            r_rem_est <= (IDX_W + 1)'(r_key - quot_n);
            r_idx     <= n_home;
            r_mod_cnt <= r_mod_cnt + 1'b1;
        end
        // square term for the next step is ready while the read is in flight
        if (i_cmd.probe_rd) begin
            r_sq  <= n_sq;
            r_odd <= n_odd;
        end
        if (i_cmd.advance) begin
            r_idx  <= n_idx;
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_rd) begin
            r_rd_key   <= r_key_mem[r_idx];
            r_rd_valid <= r_valid_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_key_mem[r_idx] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_valid_mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.store) begin
            r_valid_mem[r_idx] <= 1'b1;
        end
    end

    assign idx_ext = 32'(r_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.status;
            r_out_slot   <= idx_ext[qpht_pkg::SLOT_W-1:0];
            r_out_items  <= r_stored[qpht_pkg::COUNT_W-1:0];
            r_out_coll   <= r_coll;
        end
    end

    always_comb begin
        o_sts.clr_last   = (r_clr_addr == L_LAST);
        o_sts.mod_last   = (r_mod_cnt == L_MOD_LAST);
        o_sts.slot_valid = r_rd_valid;
        o_sts.key_match  = (r_rd_key == r_key);
        o_sts.at_limit   = (r_step >= r_probe_limit);
        o_sts.is_search  = r_search;
    end

    assign o_status          = r_out_status;
    assign o_slot_index      = r_out_slot;
    assign o_item_count      = r_out_items;
    assign o_collision_total = r_out_coll;

endmodule

`default_nettype wire
